/* rtl/pfa_pkg.sv */
// shared types and constants for the page frame free list allocator
// no dependencies; every other file imports this package
package pfa_pkg;

   localparam int POOL_PAGES = 128;
   localparam int PAGE_BYTES = 4096;
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int PAGE_W     = 8;
   localparam int COUNT_W    = 8;
   localparam int ADDR_W     = 19;
   localparam int IDX_W      = $clog2(POOL_PAGES);

   typedef logic [PAGE_W-1:0]  page_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [ADDR_W-1:0]  addr_type;

   // page index that stands for "none"
   localparam page_type PAGE_NONE = PAGE_W'(POOL_PAGES);

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   typedef struct packed {
      logic load;
      logic rd;
      logic wr;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic more;
   } status_type;

endpackage

/* rtl/pfa_channels.sv */
// request and response channel interfaces of the page frame allocator
// depends on pfa_pkg
interface pfa_req_if import pfa_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      action;
   count_type count;
   page_type  chain_head;

   modport source (output valid, action, count, chain_head, input ready);
   modport sink (input valid, action, count, chain_head, output ready);
endinterface

interface pfa_rsp_if import pfa_pkg::*; ();
   logic      valid;
   logic      ready;
   page_type  head_page;
   addr_type  head_address;
   count_type pages_done;
   logic      short_grant;
   logic      chain_overrun;

   modport source (output valid, head_page, head_address, pages_done, short_grant,
                   chain_overrun, input ready);
   modport sink (input valid, head_page, head_address, pages_done, short_grant,
                 chain_overrun, output ready);
endinterface

/* rtl/pfa_ctrl.sv */
// sequencer for the allocator: read / write steps per page, response slot
// depends on pfa_pkg
module pfa_ctrl import pfa_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_READ   = 2'd1;
   localparam logic [1:0] ST_WRITE  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (status.more) begin
               cmd.rd   = 1'b1;
               state_in = ST_WRITE;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_WRITE: begin
            cmd.wr   = 1'b1;
            state_in = ST_READ;
         end
         ST_FINISH: begin
            // hold the result until the output slot drains
            if (slot_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.finish) rsp_valid_in = 1'b1;
      else if (rsp_ready)      rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_rd_then_wr: assert property (@(posedge clock) disable iff (reset)
      cmd.rd |=> cmd.wr) else $error("memory read not followed by link write");
   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff) else $error("finished transaction not presented");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !req_ready) else $error("new transaction taken while busy");
`endif

endmodule

/* rtl/pfa_datapath.sv */
// next-link memory, free stack top, walk registers and result register
// depends on pfa_pkg; driven by pfa_ctrl commands
module pfa_datapath import pfa_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output status_type status,
   input  logic       req_action,
   input  count_type  req_count,
   input  page_type   req_chain_head,
   output page_type   rsp_head_page,
   output addr_type   rsp_head_address,
   output count_type  rsp_pages_done,
   output logic       rsp_short_grant,
   output logic       rsp_chain_overrun
);

   page_type               link_mem [POOL_PAGES];
   logic [POOL_PAGES-1:0]  written_ff, written_in;
   page_type               free_top_ff, free_top_in;

   logic      action_ff;
   count_type count_ff;
   page_type  cur_ff, head_ff, pg_ff, rd_data_ff;
   count_type done_ff;
   logic      rd_written_ff;

   page_type  sel_page, link, wr_data;
   logic      cur_valid, top_valid;

   page_type  head_page_ff;
   addr_type  head_address_ff;
   count_type pages_done_ff;
   logic      short_grant_ff, chain_overrun_ff;

   assign sel_page  = (action_ff == ACT_FREE) ? cur_ff : free_top_ff;
   // an entry never written still holds its reset link, index plus one
   assign link      = rd_written_ff ? rd_data_ff : pg_ff + PAGE_W'(1);
   assign wr_data   = (action_ff == ACT_FREE) ? free_top_ff : head_ff;
   assign cur_valid = cur_ff < PAGE_NONE;
   assign top_valid = free_top_ff < PAGE_NONE;

   always_comb begin
      if (action_ff == ACT_FREE)
         status.more = cur_valid && (done_ff < COUNT_W'(POOL_PAGES));
      else
         status.more = (done_ff < count_ff) && top_valid;
   end

   always_comb begin
      written_in  = written_ff;
      free_top_in = free_top_ff;
      if (cmd.wr) begin
         written_in[pg_ff[IDX_W-1:0]] = 1'b1;
         free_top_in = (action_ff == ACT_FREE) ? pg_ff : link;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff  <= '0;
         free_top_ff <= '0;
      end else begin
         written_ff  <= written_in;
         free_top_ff <= free_top_in;
      end
   end

   // link memory, one port used per cycle
   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rd_data_ff    <= link_mem[sel_page[IDX_W-1:0]];
         rd_written_ff <= written_ff[sel_page[IDX_W-1:0]];
      end
      if (cmd.wr)
         link_mem[pg_ff[IDX_W-1:0]] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_action;
         count_ff  <= req_count;
         cur_ff    <= req_chain_head;
         head_ff   <= PAGE_NONE;
         done_ff   <= '0;
      end
      if (cmd.rd)
         pg_ff <= sel_page;
      if (cmd.wr) begin
         done_ff <= done_ff + COUNT_W'(1);
         if (action_ff == ACT_FREE)
            cur_ff <= link;
         else
            head_ff <= pg_ff;
      end
      if (cmd.finish) begin
         head_page_ff     <= head_ff;
         head_address_ff  <= (head_ff < PAGE_NONE) ?
                             ADDR_W'({head_ff, {PAGE_SHIFT{1'b0}}}) : '0;
         pages_done_ff    <= done_ff;
         short_grant_ff   <= (action_ff == ACT_ALLOC) && (done_ff < count_ff);
         chain_overrun_ff <= (action_ff == ACT_FREE) && cur_valid;
      end
   end

   assign rsp_head_page     = head_page_ff;
   assign rsp_head_address  = head_address_ff;
   assign rsp_pages_done    = pages_done_ff;
   assign rsp_short_grant   = short_grant_ff;
   assign rsp_chain_overrun = chain_overrun_ff;

`ifndef NO_ASSERTIONS
   a_done_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.wr |-> done_ff < COUNT_W'(POOL_PAGES)) else $error("page walk past pool size");
   a_wr_page_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.wr |-> pg_ff < PAGE_NONE) else $error("link write to page outside pool");
   a_load_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> done_ff == '0 && head_ff == PAGE_NONE)
      else $error("transaction start did not clear walk state");
`endif

endmodule

/* rtl/page_frame_free_list_allocator.sv */
// top level of the page frame free list allocator
// depends on pfa_pkg, pfa_channels, pfa_ctrl, pfa_datapath
//
//   channel   dir   handshake     payload
//   req_ch    in    valid/ready   action, count, chain_head
//   rsp_ch    out   valid/ready   head_page, head_address, pages_done,
//                                 short_grant, chain_overrun
//
// each page takes a registered read of the link memory then the link write;
// the link memory uses one port at a time, and one walk runs at a time.
// reset is synchronous; per-entry written bits make the memory read as the
// reset chain at once, with no clearing pass.
// a stalled response is held in its output register while the next request
// is taken and walked; the result is loaded once the register drains.
module page_frame_free_list_allocator import pfa_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   pfa_req_if.sink   req_ch,
   pfa_rsp_if.source rsp_ch
);

   cmd_type    cmd;
   status_type status;

   pfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pfa_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_action        (req_ch.action),
      .req_count         (req_ch.count),
      .req_chain_head    (req_ch.chain_head),
      .rsp_head_page     (rsp_ch.head_page),
      .rsp_head_address  (rsp_ch.head_address),
      .rsp_pages_done    (rsp_ch.pages_done),
      .rsp_short_grant   (rsp_ch.short_grant),
      .rsp_chain_overrun (rsp_ch.chain_overrun)
   );

endmodule

/* test/page_frame_free_list_allocator_test.sv */
`timescale 1ns / 1ps
// testbench for page_frame_free_list_allocator: a table of directed requests, then random
// allocate and free traffic, checked against table rows or a free-list predictor
// depends on pfa_pkg, pfa_channels and the allocator rtl
module page_frame_free_list_allocator_test;
   import pfa_pkg::*;

   localparam int RANDOM_ITEMS = 1230;
   localparam int QUIET_LIMIT  = 20000;
   localparam int DRAIN_CYCLES = 300;
   localparam int HOLD_CYCLES  = 400;

   typedef struct packed {
      page_type  head_page;
      addr_type  head_address;
      count_type pages_done;
      logic      short_grant;
      logic      chain_overrun;
   } outcome_type;

   typedef struct packed {
      logic        action;
      count_type   count;
      page_type    chain_head;
      logic        typed;
      outcome_type want;
   } table_row_type;

   localparam outcome_type NOTHING_MOVED = '{PAGE_NONE, 19'd0, 8'd0, 1'b0, 1'b0};

   // rows 13 to 17 build a cycle through the whole pool, walk it, then pop it apart;
   // the pool ends whole and in reset order
   localparam table_row_type DIRECTED_ROWS [19] = '{
      // zero count straight after reset
      '{ACT_ALLOC, 8'd0,   8'hA5, 1'b1, NOTHING_MOVED},
      '{ACT_ALLOC, 8'd1,   8'h00, 1'b1, '{8'd0, 19'd0, 8'd1, 1'b0, 1'b0}},
      '{ACT_ALLOC, 8'd3,   8'hFF, 1'b1, '{8'd3, 19'd12288, 8'd3, 1'b0, 1'b0}},
      // heads at or beyond the pool size walk nothing
      '{ACT_FREE,  8'h5A,  8'd128, 1'b1, NOTHING_MOVED},
      '{ACT_FREE,  8'hFF,  8'd255, 1'b1, NOTHING_MOVED},
      '{ACT_FREE,  8'h00,  8'd200, 1'b1, NOTHING_MOVED},
      '{ACT_FREE,  8'h00,  8'd3,   1'b1, '{PAGE_NONE, 19'd0, 8'd3, 1'b0, 1'b0}},
      '{ACT_FREE,  8'h00,  8'd0,   1'b1, '{PAGE_NONE, 19'd0, 8'd1, 1'b0, 1'b0}},
      // widest count drains the pool and falls short
      '{ACT_ALLOC, 8'd255, 8'h00, 1'b1, '{8'd127, 19'd520192, 8'd128, 1'b1, 1'b0}},
      '{ACT_ALLOC, 8'd1,   8'h00, 1'b1, '{PAGE_NONE, 19'd0, 8'd0, 1'b1, 1'b0}},
      '{ACT_ALLOC, 8'd0,   8'h00, 1'b1, NOTHING_MOVED},
      '{ACT_FREE,  8'h00,  8'd127, 1'b1, '{PAGE_NONE, 19'd0, 8'd128, 1'b0, 1'b0}},
      '{ACT_ALLOC, 8'd128, 8'h00, 1'b1, '{8'd127, 19'd520192, 8'd128, 1'b0, 1'b0}},
      '{ACT_FREE,  8'h00,  8'd0,   1'b1, '{PAGE_NONE, 19'd0, 8'd1, 1'b0, 1'b0}},
      // double free of page 0 closes the free stack into a ring
      '{ACT_FREE,  8'h00,  8'd127, 1'b1, '{PAGE_NONE, 19'd0, 8'd128, 1'b0, 1'b0}},
      '{ACT_FREE,  8'h00,  8'd0,   1'b1, '{PAGE_NONE, 19'd0, 8'd128, 1'b0, 1'b1}},
      '{ACT_ALLOC, 8'd128, 8'h00, 1'b1, '{8'd0, 19'd0, 8'd128, 1'b0, 1'b0}},
      '{ACT_ALLOC, 8'd5,   8'h3C, 1'b0, NOTHING_MOVED},
      '{ACT_FREE,  8'hC3,  8'd4,   1'b0, NOTHING_MOVED}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   pfa_req_if req_ch ();
   pfa_rsp_if rsp_ch ();

   page_frame_free_list_allocator i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state: the next-link memory and the top of the free stack
   page_type    link_mem [POOL_PAGES];
   page_type    free_top;

   outcome_type pending_outcomes [$];
   page_type    held_chains [$];
   int          pages_free    = POOL_PAGES;
   int unsigned req_gap_pct   = 6;
   int unsigned rsp_stall_pct = 68;
   int unsigned rsp_hold_left = 0;
   int unsigned errors        = 0;
   int unsigned n_alloc       = 0;
   int unsigned n_free        = 0;
   int unsigned n_short       = 0;
   int unsigned n_overrun     = 0;
   int unsigned n_checked     = 0;

   function automatic outcome_type apply_to_free_list(input logic action,
                                                      input count_type count,
                                                      input page_type chain_head);
      outcome_type res;
      page_type    chain;
      page_type    cur;
      page_type    nxt;
      int          moved;
      res   = NOTHING_MOVED;
      chain = PAGE_NONE;
      moved = 0;
      if (action == ACT_ALLOC) begin
         // each popped page goes on top of the new chain
         while (moved < int'(count) && free_top < POOL_PAGES) begin
            cur                        = free_top;
            free_top                   = link_mem[cur[IDX_W-1:0]];
            link_mem[cur[IDX_W-1:0]]   = chain;
            chain                      = cur;
            moved++;
         end
         res.head_page   = chain;
         res.short_grant = moved < int'(count);
         if (chain < POOL_PAGES) res.head_address = addr_type'(int'(chain) * PAGE_BYTES);
      end else begin
         cur = chain_head;
         while (cur < POOL_PAGES && moved < POOL_PAGES) begin
            nxt                        = link_mem[cur[IDX_W-1:0]];
            link_mem[cur[IDX_W-1:0]]   = free_top;
            free_top                   = cur;
            cur                        = nxt;
            moved++;
         end
         res.chain_overrun = cur < POOL_PAGES;
      end
      res.pages_done = count_type'(moved);
      return res;
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance with valid
   // still high, so the caller decides the next value of valid in that step
   task automatic offer_request(input logic action, input count_type count,
                                input page_type chain_head, input logic typed,
                                input outcome_type want, output outcome_type predicted);
      predicted = apply_to_free_list(action, count, chain_head);
      while ($urandom_range(99) < req_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.action     <= action;
      req_ch.count      <= count;
      req_ch.chain_head <= chain_head;
      do @(posedge clock); while (!req_ch.ready);
      pending_outcomes.push_back(typed ? want : predicted);
      if (action == ACT_ALLOC) begin
         n_alloc++;
         pages_free -= int'(predicted.pages_done);
      end else begin
         n_free++;
         pages_free += int'(predicted.pages_done);
      end
      @(negedge clock);
   endtask

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         errors++;
      end
   endtask

   // response side: ready pattern, with long hold-offs on request
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_hold_left--;
         end else begin
            rsp_ch.ready <= $urandom_range(99) >= rsp_stall_pct;
         end
      end
   end

   // response checking and watchdog
   initial begin
      outcome_type seen;
      outcome_type want;
      int unsigned quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
               seen.head_page     = rsp_ch.head_page;
               seen.head_address  = rsp_ch.head_address;
               seen.pages_done    = rsp_ch.pages_done;
               seen.short_grant   = rsp_ch.short_grant;
               seen.chain_overrun = rsp_ch.chain_overrun;
               if (pending_outcomes.size() == 0) begin
                  $error("unexpected response transaction: head_page %0d, pages_done %0d",
                         seen.head_page, seen.pages_done);
                  errors++;
               end else begin
                  want = pending_outcomes.pop_front();
                  compare_field("head_page", want.head_page, seen.head_page);
                  compare_field("head_address", want.head_address, seen.head_address);
                  compare_field("pages_done", want.pages_done, seen.pages_done);
                  compare_field("short_grant", want.short_grant, seen.short_grant);
                  compare_field("chain_overrun", want.chain_overrun, seen.chain_overrun);
                  if (want.short_grant) n_short++;
                  if (want.chain_overrun) n_overrun++;
                  n_checked++;
               end
            end
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
               quiet = 0;
            end else begin
               quiet++;
            end
            if (quiet == QUIET_LIMIT) begin
               $display("no transaction for %0d cycles", QUIET_LIMIT);
               $display("SCOREBOARD MISMATCH");
               $finish;
            end
         end
      end
   end

   // request side: directed table, then random traffic in three idling phases
   initial begin
      outcome_type got;
      logic        action;
      count_type   count;
      page_type    head;
      int          pick;
      int unsigned roll;
      req_ch.valid      <= 1'b0;
      req_ch.action     <= ACT_ALLOC;
      req_ch.count      <= '0;
      req_ch.chain_head <= '0;
      foreach (link_mem[i]) link_mem[i] = page_type'(i + 1);
      free_top = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED_ROWS[r]) begin
         offer_request(DIRECTED_ROWS[r].action, DIRECTED_ROWS[r].count,
                       DIRECTED_ROWS[r].chain_head, DIRECTED_ROWS[r].typed,
                       DIRECTED_ROWS[r].want, got);
      end
      // the table leaves every page on the free stack
      pages_free = POOL_PAGES;

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3 || n == 2 * RANDOM_ITEMS / 3) begin
            // wait for every response before the idling pattern changes
            req_ch.valid <= 1'b0;
            do @(negedge clock); while (pending_outcomes.size() != 0);
            req_gap_pct   = (n == RANDOM_ITEMS / 3) ? 68 : 0;
            rsp_stall_pct = (n == RANDOM_ITEMS / 3) ? 6 : 0;
         end
         if (n == RANDOM_ITEMS / 6 || n == 5 * RANDOM_ITEMS / 6) rsp_hold_left = HOLD_CYCLES;

         roll  = $urandom_range(99);
         count = count_type'($urandom_range(255));
         head  = page_type'($urandom_range(255));
         if (roll < 4) begin
            // stray head beyond the pool
            action = ACT_FREE;
            head   = page_type'($urandom_range(255, POOL_PAGES));
         end else if (roll < 8) begin
            // ask for nothing, or for more than is left
            action = ACT_ALLOC;
            count  = (roll < 5) ? count_type'(0)
                                : count_type'($urandom_range(255, pages_free + 1));
         end else if (held_chains.size() != 0 && (pages_free < 24 || roll < 52)) begin
            action = ACT_FREE;
            pick   = $urandom_range(held_chains.size() - 1);
            head   = held_chains[pick];
            held_chains.delete(pick);
         end else begin
            action = ACT_ALLOC;
            roll   = $urandom_range(99);
            if (roll < 70) count = count_type'($urandom_range(8, 1));
            else if (roll < 92) count = count_type'($urandom_range(32, 9));
            else count = count_type'($urandom_range(128, 33));
         end
         offer_request(action, count, head, 1'b0, NOTHING_MOVED, got);
         if (action == ACT_ALLOC && got.pages_done != 0) held_chains.push_back(got.head_page);
      end

      req_ch.valid <= 1'b0;
      do @(negedge clock); while (pending_outcomes.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("covered %0d allocations and %0d chain frees, %0d responses compared",
               n_alloc, n_free, n_checked);
      $display("of those, %0d short grants and %0d overrun walks", n_short, n_overrun);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
